@@ design/swm_pkg.sv @@
// Shared types and constants for the sliding window max smoother.
package swm_pkg;

  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned SCORE_BITS = 16;
  localparam int unsigned POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned CMP_W      = (WIN_W > CFG_W) ? WIN_W : CFG_W;

  localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(8);

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic clr;
    logic wr;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  vld;
    logic [SCORE_BITS-1:0] max;
  } token_t;

endpackage

@@ design/swm_cell.sv @@
// One window slot with its stage of the running-maximum chain.
module swm_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  swm_pkg::cell_ctrl_t             ctrl_i,
  input  logic [swm_pkg::SCORE_BITS-1:0]  score_i,
  input  swm_pkg::token_t                 tok_i,
  output swm_pkg::token_t                 tok_o
);

  logic [swm_pkg::SCORE_BITS-1:0] slot_q, slot_d;
  swm_pkg::token_t                tok_q, tok_d;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.clr) begin
      slot_d = '0;
    end else if (ctrl_i.wr) begin
      slot_d = score_i;
    end
  end

  always_comb begin
    tok_d.vld = tok_i.vld;
    tok_d.max = (slot_q > tok_i.max) ? slot_q : tok_i.max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      tok_q  <= '0;
    end else begin
      slot_q <= slot_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ design/sliding_window_max_smoother.sv @@
// Sliding window maximum filter over detection scores, top level.
//
// Input channel (in_valid_i/in_ready_o): one beat carries req_type_i and
// score_i. A push stores the score in the ring at the write position; a
// clear zeroes the ring, the position and the warm flag.
// Output channel (out_valid_o/out_ready_i): one beat per input beat with
// max_score_o, the maximum over the window, and warmed_o, set once the
// write position has wrapped since the last clear.
// Config channel (cfg_valid_i/cfg_ready_o): window_size_i, 0 acts as 1 and
// values above 64 act as 64; a write also clears the window. Always ready.
// Timing: the maximum runs through a chain of 64 cells, one per cycle; a
// beat passes the start register, the cells, a pending register and the
// output register. One beat is in flight at a time.
// A finished result sits in the output register; the next input beat is
// taken while it waits, and a second result is held until the first leaves.
// Reset: all slots zero, window size 8, position and warm flag cleared.
module sliding_window_max_smoother (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [swm_pkg::SCORE_BITS-1:0]  score_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [swm_pkg::SCORE_BITS-1:0]  max_score_o,
  output logic                            warmed_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]       window_size_i
);

  swm_pkg::state_e state_q, state_d;

  logic [swm_pkg::CFG_W-1:0]      win_q, win_d;
  logic [swm_pkg::POS_W-1:0]      pos_q, pos_d;
  logic                           warm_q, warm_d;
  logic                           start_q;
  logic [swm_pkg::SCORE_BITS-1:0] pend_q;
  logic                           out_valid_q, out_valid_d;
  logic [swm_pkg::SCORE_BITS-1:0] max_q;
  logic                           warmed_q;

  logic                     in_acc, cfg_acc, push_acc, clr_acc, out_load;
  logic [swm_pkg::CMP_W-1:0] win_ext, win_eff, pos_inc;

  swm_pkg::token_t    tok [swm_pkg::MAX_WINDOW+1];
  swm_pkg::cell_ctrl_t ctrl [swm_pkg::MAX_WINDOW];

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign push_acc    = in_acc && (req_type_i == swm_pkg::REQ_PUSH);
  assign clr_acc     = in_acc && (req_type_i == swm_pkg::REQ_CLEAR);

  // effective window, clamped to 1..MAX_WINDOW
  assign win_ext = swm_pkg::CMP_W'(win_q);
  always_comb begin
    if (win_ext == '0) begin
      win_eff = swm_pkg::CMP_W'(1);
    end else if (win_ext > swm_pkg::CMP_W'(swm_pkg::MAX_WINDOW)) begin
      win_eff = swm_pkg::CMP_W'(swm_pkg::MAX_WINDOW);
    end else begin
      win_eff = win_ext;
    end
  end

  assign pos_inc = swm_pkg::CMP_W'(pos_q) + swm_pkg::CMP_W'(1);

  always_comb begin
    win_d  = win_q;
    pos_d  = pos_q;
    warm_d = warm_q;
    if (cfg_acc) begin
      win_d  = window_size_i;
      pos_d  = '0;
      warm_d = 1'b0;
    end else if (clr_acc) begin
      pos_d  = '0;
      warm_d = 1'b0;
    end else if (push_acc) begin
      if (pos_inc >= win_eff) begin
        pos_d  = '0;
        warm_d = 1'b1;
      end else begin
        pos_d = pos_inc[swm_pkg::POS_W-1:0];
      end
    end
  end

  // cell chain
  assign tok[0].vld = start_q;
  assign tok[0].max = '0;

  for (genvar k = 0; k < swm_pkg::MAX_WINDOW; k++) begin : g_cell
    assign ctrl[k].clr = clr_acc || cfg_acc;
    assign ctrl[k].wr  = push_acc && (pos_q == swm_pkg::POS_W'(k));

    swm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[k]),
      .score_i (score_i),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = swm_pkg::ST_SWEEP;
        end
      end
      swm_pkg::ST_SWEEP: begin
        if (tok[swm_pkg::MAX_WINDOW].vld) begin
          state_d = swm_pkg::ST_WAIT;
        end
      end
      swm_pkg::ST_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = swm_pkg::ST_IDLE;
        end
      end
      default: state_d = swm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      swm_pkg::ST_IDLE:  in_ready_o = 1'b1;
      swm_pkg::ST_SWEEP: ;
      swm_pkg::ST_WAIT:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swm_pkg::ST_IDLE;
      win_q       <= swm_pkg::WIN_RESET;
      pos_q       <= '0;
      warm_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      pos_q       <= pos_d;
      warm_q      <= warm_d;
      start_q     <= in_acc;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[swm_pkg::MAX_WINDOW].vld) begin
      pend_q <= tok[swm_pkg::MAX_WINDOW].max;
    end
    if (out_load) begin
      max_q    <= pend_q;
      warmed_q <= warm_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_score_o = max_q;
  assign warmed_o    = warmed_q;

endmodule

@@ design/swm_checker.sv @@
// Port-level checks for the sliding window max smoother, bound to the top.
module swm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [swm_pkg::SCORE_BITS-1:0]  max_score_o,
  input logic                            warmed_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(max_score_o) && $stable(warmed_o))
    else $error("result payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while a beat is in flight");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared with no beat in flight");

endmodule

bind sliding_window_max_smoother swm_checker u_swm_checker (.*);

@@ tb/sv/swm_max_checker.sv @@
`timescale 1ns / 1ps
// Checker for the smoother: watches all three channels, predicts each result and compares.
module swm_max_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           req_type_i,
  input  logic [swm_pkg::SCORE_BITS-1:0] score_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [swm_pkg::SCORE_BITS-1:0] max_score_i,
  input  logic                           warmed_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [swm_pkg::CFG_W-1:0]      window_size_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    compared_o
);

  typedef struct packed {
    logic [swm_pkg::SCORE_BITS-1:0] max_score;
    logic                           warmed;
  } smoothed_t;

  logic [swm_pkg::SCORE_BITS-1:0] slots [swm_pkg::MAX_WINDOW];
  int unsigned                    wr_pos;
  logic                           warm;
  logic [swm_pkg::CFG_W-1:0]      win_reg;
  smoothed_t                      expected_maxima [$];

  function automatic int unsigned span();
    if (win_reg == '0) return 1;
    if (win_reg > swm_pkg::MAX_WINDOW) return swm_pkg::MAX_WINDOW;
    return 32'(win_reg);
  endfunction

  function automatic void clear_window();
    foreach (slots[i]) slots[i] = '0;
    wr_pos = 0;
    warm   = 1'b0;
  endfunction

  function automatic smoothed_t window_max_after(
      input logic                           req,
      input logic [swm_pkg::SCORE_BITS-1:0] score);
    smoothed_t   res;
    int unsigned win;
    win = span();
    res = '0;
    if (req == swm_pkg::REQ_CLEAR) begin
      clear_window();
      return res;
    end
    if (wr_pos >= win) wr_pos = 0;
    slots[wr_pos] = score;
    wr_pos++;
    if (wr_pos >= win) wr_pos = 0;
    if (wr_pos == 0) warm = 1'b1;
    // unwritten slots hold zero and still count
    for (int i = 0; i < win; i++) begin
      if (slots[i] > res.max_score) res.max_score = slots[i];
    end
    res.warmed = warm;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    smoothed_t want;
    if (!rst_ni) begin
      clear_window();
      win_reg = swm_pkg::WIN_RESET;
      expected_maxima.delete();
      mismatch_count_o = 0;
      compared_o       = 0;
      pending_o        = 0;
    end else begin
      // results belong to earlier beats, so retire before taking a new one
      if (out_valid_i && out_ready_i) begin
        if (expected_maxima.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: unexpected result beat max_score %h warmed %b",
                     $realtime, max_score_i, warmed_i);
        end else begin
          want = expected_maxima.pop_front();
          compared_o++;
          if (max_score_i !== want.max_score || warmed_i !== want.warmed) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%0t: result %0d max_score exp %h got %h, warmed exp %b got %b",
                       $realtime, compared_o, want.max_score, max_score_i,
                       want.warmed, warmed_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        win_reg = window_size_i;
        clear_window();
      end
      if (in_valid_i && in_ready_i)
        expected_maxima.push_back(window_max_after(req_type_i, score_i));
      pending_o = expected_maxima.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus, output back-pressure and final verdict.
module testbench;

  localparam int unsigned ITEMS        = 1750;
  localparam int unsigned RX_HOLD      = 600;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           req_type_i;
  logic [swm_pkg::SCORE_BITS-1:0] score_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [swm_pkg::SCORE_BITS-1:0] max_score_o;
  logic                           warmed_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [swm_pkg::CFG_W-1:0]      window_size_i;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_req;
  int unsigned beats_sent;
  int unsigned clears_sent;
  int unsigned cfg_writes;
  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned compared;

  sliding_window_max_smoother dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .score_i      (score_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .max_score_o  (max_score_o),
    .warmed_o     (warmed_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .window_size_i(window_size_i)
  );

  swm_max_checker checker_u (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .req_type_i      (req_type_i),
    .score_i         (score_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .max_score_i     (max_score_o),
    .warmed_i        (warmed_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .window_size_i   (window_size_i),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .compared_o      (compared)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // output side: random stalls, plus a long hold-off when requested
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = RX_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic req, input logic [swm_pkg::SCORE_BITS-1:0] score);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    score_i    <= score;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (req == swm_pkg::REQ_CLEAR) clears_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] value);
    drain_results();
    cfg_valid_i   <= 1'b1;
    window_size_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [swm_pkg::SCORE_BITS-1:0] pick_score();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return swm_pkg::SCORE_BITS'($urandom_range(255));
      default: return swm_pkg::SCORE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [swm_pkg::CFG_W-1:0] pick_window();
    case ($urandom_range(9))
      0:       return '0;
      1:       return swm_pkg::CFG_W'($urandom_range(swm_pkg::MAX_WINDOW + 1, 127));
      2:       return swm_pkg::CFG_W'(swm_pkg::MAX_WINDOW);
      3:       return swm_pkg::CFG_W'($urandom_range(13, swm_pkg::MAX_WINDOW - 1));
      default: return swm_pkg::CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    int unsigned               rand_sent;
    int unsigned               seg;
    int unsigned               len;
    int unsigned               phase;
    bit                        held;
    logic [swm_pkg::CFG_W-1:0] win;
    rand_sent     = 0;
    seg           = 0;
    held          = 1'b0;
    tx_idle_pct   = 31;
    rx_idle_pct   = 64;
    hold_req      = 0;
    beats_sent    = 0;
    clears_sent   = 0;
    cfg_writes    = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = swm_pkg::REQ_PUSH;
    score_i       = '0;
    cfg_valid_i   = 1'b0;
    window_size_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset window of 8, wrap, expiry of the maximum, clears
    send_beat(swm_pkg::REQ_CLEAR, 16'hFFFF);
    send_beat(swm_pkg::REQ_PUSH, 16'h0000);
    send_beat(swm_pkg::REQ_PUSH, 16'hFFFF);
    send_beat(swm_pkg::REQ_PUSH, 16'h5555);
    send_beat(swm_pkg::REQ_PUSH, 16'hAAAA);
    send_beat(swm_pkg::REQ_PUSH, 16'h0001);
    send_beat(swm_pkg::REQ_PUSH, 16'h8000);
    send_beat(swm_pkg::REQ_PUSH, 16'h7FFF);
    send_beat(swm_pkg::REQ_PUSH, 16'h1234);
    send_beat(swm_pkg::REQ_PUSH, 16'h0002);
    send_beat(swm_pkg::REQ_PUSH, 16'h0003);
    send_beat(swm_pkg::REQ_CLEAR, 16'h1234);
    send_beat(swm_pkg::REQ_PUSH, 16'h00FF);
    // zero window acts as one
    write_window('0);
    send_beat(swm_pkg::REQ_PUSH, 16'hABCD);
    send_beat(swm_pkg::REQ_PUSH, 16'h0001);
    // oversize window saturates
    write_window('1);
    send_beat(swm_pkg::REQ_PUSH, 16'hFFFF);
    send_beat(swm_pkg::REQ_PUSH, 16'h0005);
    send_beat(swm_pkg::REQ_CLEAR, 16'hFFFF);
    write_window(swm_pkg::CFG_W'(swm_pkg::MAX_WINDOW));
    send_beat(swm_pkg::REQ_PUSH, 16'h4321);
    write_window(swm_pkg::CFG_W'(swm_pkg::MAX_WINDOW + 1));
    send_beat(swm_pkg::REQ_PUSH, 16'h0010);
    write_window(swm_pkg::CFG_W'(1));
    send_beat(swm_pkg::REQ_PUSH, 16'hFFFE);

    while (rand_sent < ITEMS) begin
      phase = rand_sent * 3 / ITEMS;
      tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 64 : 0;
      rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 31 : 0;
      win = pick_window();
      write_window(win);
      // output stalls long enough to back up the input side
      if (phase == 2 && !held) begin
        held = 1'b1;
        hold_req++;
      end
      len = 2 * ((win > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : win)
            + $urandom_range(2, 20);
      for (int k = 0; k < len && rand_sent < ITEMS; k++) begin
        if (k == len / 2 && seg % 4 == 1) drain_results();
        if ($urandom_range(99) < 4)
          send_beat(swm_pkg::REQ_CLEAR, swm_pkg::SCORE_BITS'($urandom()));
        else send_beat(swm_pkg::REQ_PUSH, pick_score());
        rand_sent++;
      end
      seg++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run: %0d beats (%0d clears), %0d window writes, %0d results compared",
             beats_sent, clears_sent, cfg_writes, compared);
    $display("Windows of 0, 1, 8, 64 and above 64; idle on either side, a long output stall");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
